### design/segscan_pkg.sv
// ----------------------------------------------------------------------------
// segscan_pkg
// Shared types, command codes and display tables for the seven-segment
// scan controller.
// ----------------------------------------------------------------------------
package segscan_pkg;

  localparam int SlotCount = 12;
  localparam int FontSize  = 43;

  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_NUMBER = 3'd1;
  localparam logic [2:0] CMD_CHAR   = 3'd2;
  localparam logic [2:0] CMD_POINT  = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;

  localparam logic [7:0] BLANK_CODE = 8'd11;
  localparam logic [7:0] CHAR_BASE  = 8'h30;
  localparam logic [3:0] LAST_PHASE = 4'd11;

  typedef enum logic {
    ST_IDLE,
    ST_CONV
  } state_t;

  typedef struct packed {
    logic       tick;
    logic       set_char;
    logic       set_point;
    logic       clr_points;
    logic       set_num;
    logic [1:0] indicator;
    logic [3:0] slot;
    logic [7:0] code;
    logic [1:0] dig;
    logic       on;
  } store_ctrl_t;

  typedef struct packed {
    logic       done;
    logic [3:0] d3;
    logic [3:0] d2;
    logic [3:0] d1;
    logic [3:0] d0;
  } bcd_status_t;

  typedef struct packed {
    logic [15:0] spi_word;
    logic [3:0]  line_select;
    logic [3:0]  phase;
  } scan_t;

  function automatic logic [7:0] font_lookup(input logic [7:0] code);
    logic [7:0] seg;
    case (code)
      8'd0:    seg = 8'h3F;
      8'd1:    seg = 8'h0C;
      8'd2:    seg = 8'h6B;
      8'd3:    seg = 8'h6D;
      8'd4:    seg = 8'h5C;
      8'd5:    seg = 8'h75;
      8'd6:    seg = 8'h77;
      8'd7:    seg = 8'h2C;
      8'd8:    seg = 8'h7F;
      8'd9:    seg = 8'h7D;
      8'd17:   seg = 8'h7E;
      8'd18:   seg = 8'h57;
      8'd19:   seg = 8'h33;
      8'd20:   seg = 8'h4F;
      8'd21:   seg = 8'h73;
      8'd22:   seg = 8'h72;
      8'd23:   seg = 8'h37;
      8'd24:   seg = 8'h5E;
      8'd25:   seg = 8'h04;
      8'd26:   seg = 8'h0D;
      8'd28:   seg = 8'h13;
      8'd30:   seg = 8'h46;
      8'd31:   seg = 8'h47;
      8'd32:   seg = 8'h7A;
      8'd33:   seg = 8'h7C;
      8'd34:   seg = 8'h42;
      8'd36:   seg = 8'h53;
      8'd37:   seg = 8'h07;
      8'd41:   seg = 8'h5D;
      8'd42:   seg = 8'h43;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

  function automatic logic [7:0] row_lookup(input logic [2:0] ph);
    logic [7:0] addr;
    case (ph)
      3'd0:    addr = 8'h80;
      3'd1:    addr = 8'h40;
      3'd2:    addr = 8'h08;
      3'd3:    addr = 8'h10;
      3'd4:    addr = 8'h20;
      3'd5:    addr = 8'h04;
      3'd6:    addr = 8'h02;
      default: addr = 8'h01;
    endcase
    return addr;
  endfunction

endpackage

### design/segscan_bcd.sv
// ----------------------------------------------------------------------------
// segscan_bcd
// Bit-serial binary to BCD converter (shift and add-3), one input bit per
// cycle. Keeps the four low decimal digits, i.e. the value modulo 10000.
// ----------------------------------------------------------------------------
module segscan_bcd (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [15:0]               number,
  output segscan_pkg::bcd_status_t  status
);
  import segscan_pkg::*;

  logic [15:0] sh;
  logic [15:0] bcd;
  logic [15:0] adj;
  logic [3:0]  cnt;
  logic        busy;
  logic        done;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= number;
      bcd <= '0;
    end else if (busy) begin
      bcd <= {adj[14:0], sh[15]};
      sh  <= {sh[14:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == 4'hF);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 4'd1;
        if (cnt == 4'hF) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign status.done = done;
  assign status.d3   = bcd[15:12];
  assign status.d2   = bcd[11:8];
  assign status.d1   = bcd[7:4];
  assign status.d0   = bcd[3:0];

endmodule

### design/segscan_store.sv
// ----------------------------------------------------------------------------
// segscan_store
// Character codes, decimal points and scan phase, with number blanking and
// the scan word built for the next phase.
// ----------------------------------------------------------------------------
module segscan_store (
  input  logic                      clk,
  input  logic                      rst,
  input  segscan_pkg::store_ctrl_t  ctrl,
  input  segscan_pkg::bcd_status_t  digits,
  output segscan_pkg::scan_t        scan
);
  import segscan_pkg::*;

  logic [7:0]  codes [SlotCount];
  logic [11:0] points;
  logic [3:0]  phase;
  logic [3:0]  phase_next;
  logic [7:0]  seg;
  logic [7:0]  addr;
  logic [3:0]  lines;
  logic [3:0]  pt_bit;
  logic        pt_ok;
  logic [7:0]  c3, c2, c1, c0;
  logic        z3, z2, z1;

  assign c3 = {4'd0, digits.d3};
  assign c2 = {4'd0, digits.d2};
  assign c1 = {4'd0, digits.d1};
  assign c0 = {4'd0, digits.d0};
  assign z3 = (digits.d3 == 4'd0);
  assign z2 = (digits.d2 == 4'd0);
  assign z1 = (digits.d1 == 4'd0);

  always_comb begin
    pt_ok  = 1'b1;
    pt_bit = 4'd0;
    case (ctrl.indicator)
      2'd0: begin
        pt_ok  = (ctrl.dig < 2'd2);
        pt_bit = 4'd1 - {2'd0, ctrl.dig};
      end
      2'd1: begin
        pt_ok  = (ctrl.dig < 2'd3);
        pt_bit = 4'd4 - {2'd0, ctrl.dig};
      end
      2'd2: begin
        pt_ok  = (ctrl.dig < 2'd3);
        pt_bit = 4'd7 - {2'd0, ctrl.dig};
      end
      default: begin
        pt_ok  = 1'b1;
        pt_bit = 4'd11 - {2'd0, ctrl.dig};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SlotCount; i++) begin
        codes[i] <= '0;
      end
    end else if (ctrl.set_char && (ctrl.slot <= LAST_PHASE)) begin
      codes[ctrl.slot] <= ctrl.code;
    end else if (ctrl.set_num) begin
      case (ctrl.indicator)
        2'd0: begin
          codes[0] <= c1;
          codes[1] <= c0;
        end
        2'd1: begin
          codes[2] <= z2 ? BLANK_CODE : c2;
          codes[3] <= (z2 && z1 && !points[3]) ? BLANK_CODE : c1;
          codes[4] <= c0;
        end
        2'd2: begin
          codes[5] <= z2 ? BLANK_CODE : c2;
          codes[6] <= (z2 && z1) ? BLANK_CODE : c1;
          codes[7] <= c0;
        end
        default: begin
          codes[8]  <= z3 ? BLANK_CODE : c3;
          codes[9]  <= (z3 && z2) ? BLANK_CODE : c2;
          codes[10] <= (z3 && z2 && z1 && !points[10]) ? BLANK_CODE : c1;
          codes[11] <= c0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      points <= '0;
      phase  <= '0;
    end else begin
      if (ctrl.clr_points) begin
        points <= '0;
      end else if (ctrl.set_point && pt_ok) begin
        points[pt_bit] <= ctrl.on;
      end
      if (ctrl.tick) begin
        phase <= phase_next;
      end
    end
  end

  assign phase_next = (phase >= LAST_PHASE) ? 4'd0 : phase + 4'd1;

  always_comb begin
    seg = font_lookup(codes[phase_next]);
    seg[7] = seg[7] | points[phase_next];
    if (phase_next[3]) begin
      addr  = 8'h00;
      lines = 4'b0001 << phase_next[1:0];
    end else begin
      addr  = row_lookup(phase_next[2:0]);
      lines = 4'b0000;
    end
  end

  assign scan.spi_word    = {~addr, seg};
  assign scan.line_select = lines;
  assign scan.phase       = phase_next;

endmodule

### design/seven_segment_scan_controller_top.sv
// ----------------------------------------------------------------------------
// seven_segment_scan_controller_top
// Scan controller for a 12-digit multiplexed seven-segment display.
// ----------------------------------------------------------------------------
// Scan ticks, set character, set point and clear points act at the edge where
// they are accepted; a scan tick places one item in the output register, and
// the next item can be taken at the same edge where that item leaves. While a
// result is held by out_stall, the input stalls for every command. Set number
// is accepted, then the bit-serial binary to BCD converter shifts in one bit
// of the number per cycle and the digits are written back; input stalls
// meanwhile.
// ----------------------------------------------------------------------------
module seven_segment_scan_controller_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  command,
  input  logic [1:0]  indicator,
  input  logic [15:0] number,
  input  logic [3:0]  slot,
  input  logic [7:0]  char_code,
  input  logic [1:0]  digit_from_right,
  input  logic        point_on,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] spi_word,
  output logic [3:0]  line_select,
  output logic [3:0]  phase_shown
);
  import segscan_pkg::*;

  state_t      state;
  state_t      state_next;
  logic        accept;
  logic        bcd_start;
  logic [1:0]  num_ind;
  store_ctrl_t ctrl;
  bcd_status_t bcd_st;
  scan_t       scan;

  assign accept = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (command == CMD_NUMBER)) begin
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        if (bcd_st.done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state != ST_IDLE) || (out_valid && out_stall);
    bcd_start = (state == ST_IDLE) && accept && (command == CMD_NUMBER);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (bcd_start) begin
      num_ind <= indicator;
    end
  end

  always_comb begin
    ctrl.tick       = accept && (command == CMD_TICK);
    ctrl.set_char   = accept && (command == CMD_CHAR);
    ctrl.set_point  = accept && (command == CMD_POINT);
    ctrl.clr_points = accept && (command == CMD_CLEAR);
    ctrl.set_num    = (state == ST_CONV) && bcd_st.done;
    ctrl.indicator  = (state == ST_CONV) ? num_ind : indicator;
    ctrl.slot       = slot;
    ctrl.code       = char_code - CHAR_BASE;
    ctrl.dig        = digit_from_right;
    ctrl.on         = point_on;
  end

  segscan_bcd u_bcd (
    .clk    (clk),
    .rst    (rst),
    .start  (bcd_start),
    .number (number),
    .status (bcd_st)
  );

  segscan_store u_store (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .digits (bcd_st),
    .scan   (scan)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.tick) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.tick) begin
      spi_word    <= scan.spi_word;
      line_select <= scan.line_select;
      phase_shown <= scan.phase;
    end
  end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the seven-segment scan controller.
// A mirror of the digit, point and phase stores predicts every scan word.
// Directed commands come first, then about 1750 random items, mostly refresh
// frames. Idle bursts on both sides, one long output hold-off and a full
// drain midway exercise the handshakes.
// ----------------------------------------------------------------------------

class display_mirror;
  logic [7:0]  seg_rom [0:42];
  logic [7:0]  row_rom [0:7];
  logic [7:0]  codes [0:11];
  logic [11:0] points;
  logic [3:0]  phase;
  segscan_pkg::scan_t pending_words [$];
  int cmd_seen [0:7];
  int unused_seen;
  int words_checked;
  int mismatches;

  function new();
    seg_rom = '{8'h3F, 8'h0C, 8'h6B, 8'h6D, 8'h5C, 8'h75, 8'h77, 8'h2C, 8'h7F, 8'h7D,
                8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                8'h7E, 8'h57, 8'h33, 8'h4F, 8'h73, 8'h72, 8'h37, 8'h5E, 8'h04, 8'h0D,
                8'h00, 8'h13, 8'h00, 8'h46, 8'h47, 8'h7A, 8'h7C, 8'h42, 8'h00, 8'h53,
                8'h07, 8'h00, 8'h00, 8'h00, 8'h5D, 8'h43};
    row_rom = '{8'h80, 8'h40, 8'h08, 8'h10, 8'h20, 8'h04, 8'h02, 8'h01};
    foreach (codes[i]) codes[i] = '0;
    foreach (cmd_seen[i]) cmd_seen[i] = 0;
    points = '0;
    phase = '0;
    unused_seen = 0;
    words_checked = 0;
    mismatches = 0;
  endfunction

  function void note_failure(string msg);
    mismatches++;
    if (mismatches <= 10) $display("ERROR: %s", msg);
  endfunction

  // Returns 1 when the item did something (not ignored).
  function bit apply_command(logic [2:0] cmd, logic [1:0] ind, logic [15:0] num,
                             logic [3:0] slt, logic [7:0] ch, logic [1:0] dig,
                             logic on);
    segscan_pkg::scan_t w;
    int n, d0, d1, d2, d3;
    int span, right_slot;
    bit acted;
    acted = 1'b1;
    n = num;
    d0 = n % 10;
    d1 = n / 10 % 10;
    d2 = n / 100 % 10;
    d3 = n / 1000 % 10;
    case (cmd)
      segscan_pkg::CMD_TICK: begin
        phase = (phase == segscan_pkg::LAST_PHASE) ? 4'd0 : phase + 4'd1;
        w.spi_word[7:0] = (codes[phase] < 43) ? seg_rom[codes[phase]] : 8'h00;
        if (points[phase]) w.spi_word[7] = 1'b1;
        if (phase < 4'd8) begin
          w.spi_word[15:8] = ~row_rom[phase[2:0]];
          w.line_select = 4'b0000;
        end else begin
          w.spi_word[15:8] = 8'hFF;
          w.line_select = 4'b0001 << (phase - 4'd8);
        end
        w.phase = phase;
        pending_words.push_back(w);
      end
      segscan_pkg::CMD_NUMBER: begin
        case (ind)
          2'd0: begin
            codes[0] = 8'(d1);
            codes[1] = 8'(d0);
          end
          2'd1: begin
            codes[2] = 8'(d2);
            codes[3] = 8'(d1);
            codes[4] = 8'(d0);
            if (d2 == 0) begin
              codes[2] = segscan_pkg::BLANK_CODE;
              if (d1 == 0 && !points[3]) codes[3] = segscan_pkg::BLANK_CODE;
            end
          end
          2'd2: begin
            codes[5] = 8'(d2);
            codes[6] = 8'(d1);
            codes[7] = 8'(d0);
            if (d2 == 0) begin
              codes[5] = segscan_pkg::BLANK_CODE;
              if (d1 == 0) codes[6] = segscan_pkg::BLANK_CODE;
            end
          end
          default: begin
            codes[8] = 8'(d3);
            codes[9] = 8'(d2);
            codes[10] = 8'(d1);
            codes[11] = 8'(d0);
            if (d3 == 0) begin
              codes[8] = segscan_pkg::BLANK_CODE;
              if (d2 == 0) begin
                codes[9] = segscan_pkg::BLANK_CODE;
                if (d1 == 0 && !points[10]) codes[10] = segscan_pkg::BLANK_CODE;
              end
            end
          end
        endcase
      end
      segscan_pkg::CMD_CHAR: begin
        if (slt < 4'd12) codes[slt] = ch - segscan_pkg::CHAR_BASE;
        else acted = 1'b0;
      end
      segscan_pkg::CMD_POINT: begin
        case (ind)
          2'd0: begin span = 2; right_slot = 1; end
          2'd1: begin span = 3; right_slot = 4; end
          2'd2: begin span = 3; right_slot = 7; end
          default: begin span = 4; right_slot = 11; end
        endcase
        if (dig < span) points[right_slot - dig] = on;
        else acted = 1'b0;
      end
      segscan_pkg::CMD_CLEAR: points = '0;
      default: begin
        unused_seen++;
        acted = 1'b0;
      end
    endcase
    if (acted) cmd_seen[cmd]++;
    return acted;
  endfunction

  function void check_scan_word(logic [15:0] word, logic [3:0] lines, logic [3:0] ph);
    segscan_pkg::scan_t w;
    if (pending_words.size() == 0) begin
      note_failure($sformatf("unexpected item: spi_word %h line_select %b phase %0d",
                             word, lines, ph));
      return;
    end
    w = pending_words.pop_front();
    words_checked++;
    if (word !== w.spi_word || lines !== w.line_select || ph !== w.phase)
      note_failure($sformatf({"word %0d: expected spi_word %h line_select %b phase %0d,",
                              " got %h %b %0d"}, words_checked, w.spi_word,
                             w.line_select, w.phase, word, lines, ph));
  endfunction
endclass

module tb;
  import segscan_pkg::*;

  localparam int ItemTarget = 1750;
  localparam int CalmTail   = 250;
  localparam int HoldCycles = 300;
  localparam int SettleCycles = 24;
  localparam int CycleLimit = 400000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  command;
  logic [1:0]  indicator;
  logic [15:0] number;
  logic [3:0]  slot;
  logic [7:0]  char_code;
  logic [1:0]  digit_from_right;
  logic        point_on;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] spi_word;
  logic [3:0]  line_select;
  logic [3:0]  phase_shown;

  display_mirror mirror;
  int items_done;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_requests;
  int cycles;

  seven_segment_scan_controller_top dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .command(command),
    .indicator(indicator),
    .number(number),
    .slot(slot),
    .char_code(char_code),
    .digit_from_right(digit_from_right),
    .point_on(point_on),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .spi_word(spi_word),
    .line_select(line_select),
    .phase_shown(phase_shown)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("seven_segment_scan_controller_top verification failed");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      mirror.check_scan_word(spi_word, line_select, phase_shown);
  end

  // Output side: random stall bursts plus a long hold-off on request.
  initial begin
    int burst;
    int holds_done;
    burst = 0;
    holds_done = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done != hold_requests) begin
        holds_done++;
        out_stall = 1'b1;
        repeat (HoldCycles) @(negedge clk);
      end else if (burst > 0) begin
        burst--;
        out_stall = 1'b1;
      end else if (recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct) begin
        burst = $urandom_range(0, 14);
        out_stall = 1'b1;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  task automatic idle_sender(input int n);
    @(negedge clk);
    in_valid = 1'b0;
    command = 3'($urandom);
    number = 16'($urandom);
    char_code = 8'($urandom);
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic offer_item(input logic [2:0] cmd, input logic [1:0] ind,
                            input logic [15:0] num, input logic [3:0] slt,
                            input logic [7:0] ch, input logic [1:0] dig,
                            input logic on);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
      idle_sender($urandom_range(1, 15));
    @(negedge clk);
    in_valid = 1'b1;
    command = cmd;
    indicator = ind;
    number = num;
    slot = slt;
    char_code = ch;
    digit_from_right = dig;
    point_on = on;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (mirror.apply_command(cmd, ind, num, slt, ch, dig, on)) items_done++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (mirror.pending_words.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  function automatic logic [15:0] pick_number();
    case ($urandom_range(3))
      0: return 16'($urandom_range(0, 9));
      1: return 16'($urandom_range(0, 120));
      2: return 16'($urandom_range(0, 9999));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic offer_tick();
    offer_item(CMD_TICK, 2'($urandom), 16'($urandom), 4'($urandom), 8'($urandom),
               2'($urandom), 1'($urandom));
  endtask

  // Refresh frame: optional point and a number per indicator, then a scan sweep.
  task automatic offer_frame();
    for (int g = 0; g < 4; g++) begin
      if ($urandom_range(1) == 0)
        offer_item(CMD_POINT, 2'(g), 16'($urandom), 4'($urandom), 8'($urandom),
                   2'($urandom), 1'($urandom));
      offer_item(CMD_NUMBER, 2'(g), pick_number(), 4'($urandom), 8'($urandom),
                 2'($urandom), 1'($urandom));
    end
    repeat ($urandom_range(12, 24)) offer_tick();
  endtask

  task automatic offer_random_item();
    logic [2:0] cmd;
    logic [3:0] slt;
    logic [7:0] ch;
    int pick;
    pick = $urandom_range(99);
    if (pick < 50) cmd = CMD_TICK;
    else if (pick < 64) cmd = CMD_NUMBER;
    else if (pick < 78) cmd = CMD_CHAR;
    else if (pick < 93) cmd = CMD_POINT;
    else if (pick < 96) cmd = CMD_CLEAR;
    else cmd = 3'($urandom_range(CMD_CLEAR + 1, 7));
    slt = ($urandom_range(7) == 0) ? 4'($urandom_range(12, 15)) : 4'($urandom_range(0, 11));
    ch = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(8'h30, 8'h5A));
    offer_item(cmd, 2'($urandom), pick_number(), slt, ch, 2'($urandom), 1'($urandom));
  endtask

  function automatic int pick_idle_pct();
    case ($urandom_range(3))
      0: return 0;
      1: return 5;
      2: return 20;
      default: return 50;
    endcase
  endfunction

  initial begin
    int seg;
    int last_seg;
    bit hold_fired;
    bit pause_fired;
    mirror = new();
    items_done = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests = 0;
    last_seg = -1;
    hold_fired = 1'b0;
    pause_fired = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    command = CMD_TICK;
    indicator = '0;
    number = '0;
    slot = '0;
    char_code = '0;
    digit_from_right = '0;
    point_on = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: blanking rules, kept tens digits, font edges, ignored writes
    offer_item(CMD_TICK, 2'd0, 16'd0, 4'd0, 8'h00, 2'd0, 1'b0);
    offer_item(CMD_POINT, 2'd1, 16'd0, 4'd0, 8'h00, 2'd1, 1'b1);
    offer_item(CMD_NUMBER, 2'd1, 16'd5, 4'd0, 8'h00, 2'd0, 1'b0);
    offer_item(CMD_NUMBER, 2'd2, 16'd0, 4'd0, 8'h00, 2'd0, 1'b0);
    offer_item(CMD_NUMBER, 2'd3, 16'hFFFF, 4'd0, 8'h00, 2'd0, 1'b0);
    offer_item(CMD_POINT, 2'd3, 16'd0, 4'd0, 8'h00, 2'd1, 1'b1);
    offer_item(CMD_NUMBER, 2'd3, 16'd3, 4'd0, 8'h00, 2'd0, 1'b0);
    offer_item(CMD_NUMBER, 2'd0, 16'd99, 4'd0, 8'h00, 2'd0, 1'b0);
    offer_item(CMD_CHAR, 2'd0, 16'd0, 4'd0, 8'h20, 2'd0, 1'b0);
    offer_item(CMD_CHAR, 2'd0, 16'd0, 4'd11, 8'h5A, 2'd0, 1'b0);
    offer_item(CMD_CHAR, 2'd0, 16'd0, 4'd15, 8'hFF, 2'd0, 1'b0);
    offer_item(CMD_CHAR, 2'd0, 16'd0, 4'd5, 8'h00, 2'd0, 1'b0);
    offer_item(CMD_CHAR, 2'd0, 16'd0, 4'd6, 8'hFF, 2'd0, 1'b0);
    offer_item(CMD_POINT, 2'd0, 16'd0, 4'd0, 8'h00, 2'd2, 1'b1);
    offer_item(CMD_POINT, 2'd0, 16'd0, 4'd0, 8'h00, 2'd1, 1'b1);
    offer_item(3'd7, 2'd3, 16'hFFFF, 4'd15, 8'hFF, 2'd3, 1'b1);
    offer_item(CMD_CLEAR, 2'd0, 16'd0, 4'd0, 8'h00, 2'd0, 1'b0);
    offer_item(CMD_NUMBER, 2'd1, 16'd0, 4'd0, 8'h00, 2'd0, 1'b0);
    offer_item(CMD_POINT, 2'd2, 16'd0, 4'd0, 8'h00, 2'd0, 1'b1);
    repeat (13) offer_tick();

    while (items_done < ItemTarget) begin
      seg = items_done / 150;
      if (seg != last_seg) begin
        last_seg = seg;
        send_idle_pct = pick_idle_pct();
        recv_idle_pct = pick_idle_pct();
      end
      if (items_done >= ItemTarget - CalmTail) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (!hold_fired && items_done >= 500) begin
        hold_fired = 1'b1;
        hold_requests++;
      end
      if (!pause_fired && items_done >= 1000) begin
        pause_fired = 1'b1;
        wait_drained();
      end
      if ($urandom_range(2) == 0) offer_frame();
      else offer_random_item();
    end
    wait_drained();

    $display("%0d items: %0d scan ticks, %0d number loads, %0d characters, %0d point writes",
             items_done, mirror.cmd_seen[CMD_TICK], mirror.cmd_seen[CMD_NUMBER],
             mirror.cmd_seen[CMD_CHAR], mirror.cmd_seen[CMD_POINT]);
    $display("%0d point clears, %0d unused commands, %0d scan words compared, %0d mismatches",
             mirror.cmd_seen[CMD_CLEAR], mirror.unused_seen, mirror.words_checked,
             mirror.mismatches);
    if (mirror.mismatches == 0)
      $display("seven_segment_scan_controller_top verification clean");
    else
      $display("seven_segment_scan_controller_top verification failed");
    $finish;
  end

endmodule
